/* sv/olp_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and the quarter-wave sine table for the open-loop PWM block.
// No dependencies.
package olp_pkg;

	localparam int PWM_PERIOD      = 4200;
	localparam int SINE_TABLE_BITS = 8;
	localparam int TBL_N           = 1 << SINE_TABLE_BITS;
	localparam int K_SQRT3_2       = 28378;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CNT_W     = 13;
	localparam int ANG_W     = 16;

	// serial multiplier: 32-bit multiplicand, 16-bit multiplier, wide accumulator
	localparam int MCAND_W  = 32;
	localparam int MPLIER_W = 16;
	localparam int MSTEP_W  = $clog2(MPLIER_W);
	localparam int V_W      = 50;

	// count stage: voltages in signed Q20.30 against supply << 30
	localparam int SUP_SHIFT = 30;
	localparam int DV_W      = CFG_W + SUP_SHIFT;
	localparam int QW        = $clog2(PWM_PERIOD + 1);
	localparam int QCNT_W    = $clog2(QW);
	localparam int N_W       = DV_W + QW;

	localparam logic [CFG_IDX_W-1:0] REG_Q_VOLT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_D_VOLT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUPPLY  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_V_LIMIT = 3'd4;

	typedef logic [TBL_N-1:0][15:0] sine_tab_t;

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t t;
		longint unsigned x, x2, u, p;
		for (int i = 0; i < TBL_N; i++) begin
			x  = longint'(i) << (16 - SINE_TABLE_BITS);
			x2 = (x * x) >> 16;
			u  = 42334 - ((x2 * 5223) >> 16);
			u  = 102944 - ((x2 * u) >> 16);
			p  = ((x * u) >> 16) >> 1;
			if (p > 32767)
				p = 32767;
			t[i] = 16'(p);
		end
		return t;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

	// Q1.15 sine of a 16-bit turn fraction; quadrants mirror the table
	function automatic logic signed [15:0] sin_q15(logic [ANG_W-1:0] ang);
		logic [1:0]                 quad;
		logic [SINE_TABLE_BITS-1:0] idx;
		logic [SINE_TABLE_BITS:0]   pos;
		logic signed [15:0]         v;
		quad = ang[15:14];
		idx  = ang[13 -: SINE_TABLE_BITS];
		pos  = quad[0] ? ((SINE_TABLE_BITS + 1)'(TBL_N) - {1'b0, idx}) : {1'b0, idx};
		v    = pos[SINE_TABLE_BITS] ? 16'sd32767
		                            : $signed(SINE_TAB[pos[SINE_TABLE_BITS-1:0]]);
		return quad[1] ? -v : v;
	endfunction

endpackage

/* sv/olp_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces: tick items in, compare items out.
// Depends on olp_pkg.
interface olp_tick_if;
	logic                         valid;
	logic                         ready;
	logic [olp_pkg::CFG_W-1:0]    elapsed_us;

	modport source (output valid, output elapsed_us, input ready);
	modport sink   (input valid, input elapsed_us, output ready);
endinterface

interface olp_pwm_if;
	logic                         valid;
	logic                         ready;
	logic [olp_pkg::CNT_W-1:0]    compare_a;
	logic [olp_pkg::CNT_W-1:0]    compare_b;
	logic [olp_pkg::CNT_W-1:0]    compare_c;
	logic [olp_pkg::ANG_W-1:0]    angle_now;

	modport source (output valid, output compare_a, output compare_b, output compare_c,
		output angle_now, input ready);
	modport sink   (input valid, input compare_a, input compare_b, input compare_c,
		input angle_now, output ready);
endinterface

/* sv/olp_smac.sv */
`timescale 1ns / 1ps
// Bit-serial multiply-accumulate: one multiplier bit per cycle into a wide accumulator.
// Depends on olp_pkg.
module olp_smac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                clear,
	input  logic                                msigned,
	input  logic signed [olp_pkg::MCAND_W-1:0]  mcand,
	input  logic        [olp_pkg::MPLIER_W-1:0] mplier,
	output logic                                done,
	output logic signed [olp_pkg::V_W-1:0]      acc
);

	logic                                run_q;
	logic                                done_q;
	logic [olp_pkg::MSTEP_W-1:0]         step_q;
	logic                                sgn_q;
	logic signed [olp_pkg::V_W-1:0]      mcand_q;
	logic [olp_pkg::MPLIER_W-1:0]        mplier_q;
	logic signed [olp_pkg::V_W-1:0]      acc_q;
	logic                                last;
	logic signed [olp_pkg::V_W-1:0]      addend;

	assign last   = (step_q == olp_pkg::MSTEP_W'(olp_pkg::MPLIER_W - 1));
	// top bit of a signed multiplier carries negative weight
	assign addend = (last && sgn_q) ? -mcand_q : mcand_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (last) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= {{(olp_pkg::V_W - olp_pkg::MCAND_W){mcand[olp_pkg::MCAND_W-1]}}, mcand};
			mplier_q <= mplier;
			sgn_q    <= msigned;
			if (clear)
				acc_q <= '0;
		end else if (run_q) begin
			if (mplier_q[0])
				acc_q <= acc_q + addend;
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule

/* sv/olp_cnt.sv */
`timescale 1ns / 1ps
// Phase voltage to compare count: offset, clamp, restoring divide one quotient bit a cycle.
// Depends on olp_pkg.
module olp_cnt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [olp_pkg::V_W-1:0]    v,
	input  logic [olp_pkg::CFG_W-1:0]         supply,
	input  logic [olp_pkg::CFG_W-1:0]         limit,
	output logic                              done,
	output logic [olp_pkg::CNT_W-1:0]         count
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MUL  = 2'd1;
	localparam logic [1:0] PH_DIV  = 2'd2;

	logic [1:0]                     ph_q;
	logic                           done_q;
	logic [olp_pkg::QCNT_W-1:0]     step_q;
	logic                           zero_q;
	logic [olp_pkg::DV_W-1:0]       vcl_q;
	logic [olp_pkg::DV_W-1:0]       den_q;
	logic [olp_pkg::N_W-1:0]        rem_q;
	logic [olp_pkg::N_W-1:0]        dsh_q;
	logic [olp_pkg::QW-1:0]         quo_q;
	logic [olp_pkg::CNT_W-1:0]      count_q;

	logic signed [olp_pkg::V_W-1:0] vs;
	logic [olp_pkg::DV_W-1:0]       lim;
	logic [olp_pkg::DV_W-1:0]       vcl;
	logic                           fits;

	always_comb begin
		vs  = v + $signed({5'b0, supply, 29'b0});
		lim = {limit, 30'b0};
		if (vs[olp_pkg::V_W-1])
			vcl = '0;
		else if ($unsigned(vs) > olp_pkg::V_W'(lim))
			vcl = lim;
		else
			vcl = vs[olp_pkg::DV_W-1:0];
	end

	assign fits = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				PH_IDLE: begin
					if (start)
						ph_q <= PH_MUL;
				end
				PH_MUL: begin
					step_q <= '0;
					// zero supply and full-scale cases finish without dividing
					if (zero_q || vcl_q >= den_q) begin
						ph_q   <= PH_IDLE;
						done_q <= 1'b1;
					end else begin
						ph_q <= PH_DIV;
					end
				end
				PH_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == olp_pkg::QCNT_W'(olp_pkg::QW - 1)) begin
						ph_q   <= PH_IDLE;
						done_q <= 1'b1;
					end
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ph_q)
			PH_IDLE: begin
				if (start) begin
					vcl_q  <= vcl;
					den_q  <= {supply, 30'b0};
					zero_q <= (supply == '0);
				end
			end
			PH_MUL: begin
				rem_q <= olp_pkg::N_W'(vcl_q) * olp_pkg::N_W'(olp_pkg::PWM_PERIOD);
				dsh_q <= olp_pkg::N_W'(den_q) << (olp_pkg::QW - 1);
				quo_q <= '0;
				if (zero_q)
					count_q <= '0;
				else if (vcl_q >= den_q)
					count_q <= olp_pkg::CNT_W'(olp_pkg::PWM_PERIOD);
			end
			PH_DIV: begin
				if (fits)
					rem_q <= rem_q - dsh_q;
				dsh_q <= dsh_q >> 1;
				quo_q <= {quo_q[olp_pkg::QW-2:0], fits};
				if (step_q == olp_pkg::QCNT_W'(olp_pkg::QW - 1))
					count_q <= olp_pkg::CNT_W'({quo_q[olp_pkg::QW-2:0], fits});
			end
			default: ;
		endcase
	end

	assign done  = done_q;
	assign count = count_q;

endmodule

/* sv/open_loop_three_phase_pwm.sv */
`timescale 1ns / 1ps
// Top level: angle update, sine/cosine lookup, inverse Park/Clarke, compare counts.
// Depends on olp_pkg, olp_if, olp_smac, olp_cnt.
//
//  channel  dir  handshake      payload
//  tick     in   valid/ready    elapsed_us[15:0]
//  pwm      out  valid/ready    compare_a/b/c[12:0], angle_now[15:0]
//  cfg      in   cfg_wr_en      cfg_index[2:0], cfg_data[15:0]
//
// Each item runs nine passes of the bit-serial multiplier (angle step plus eight products)
// and up to three 13-step divides.
// One item is in work at a time; tick.ready is high only while idle.
// A finished result waits in the output register while the next item runs.
// Reset restores the default voltages, speed, supply, limit and angle zero.
module open_loop_three_phase_pwm (
	input  logic                               clk,
	input  logic                               arst_n,
	olp_tick_if.sink                           tick,
	olp_pwm_if.source                          pwm,
	input  logic                               cfg_wr_en,
	input  logic [olp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [olp_pkg::CFG_W-1:0]          cfg_data
);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_ANG_GO   = 4'd1;
	localparam logic [3:0] ST_ANG_WAIT = 4'd2;
	localparam logic [3:0] ST_TRIG     = 4'd3;
	localparam logic [3:0] ST_MUL_GO   = 4'd4;
	localparam logic [3:0] ST_MUL_WAIT = 4'd5;
	localparam logic [3:0] ST_CNT_GO   = 4'd6;
	localparam logic [3:0] ST_CNT_WAIT = 4'd7;
	localparam logic [3:0] ST_DONE     = 4'd8;

	// product sequence; b and c take two passes, a takes two then a shift
	localparam logic [2:0] JOB_KS   = 3'd0;
	localparam logic [2:0] JOB_KC   = 3'd1;
	localparam logic [2:0] JOB_B_D  = 3'd2;
	localparam logic [2:0] JOB_B_Q  = 3'd3;
	localparam logic [2:0] JOB_C_D  = 3'd4;
	localparam logic [2:0] JOB_C_Q  = 3'd5;
	localparam logic [2:0] JOB_A_D  = 3'd6;
	localparam logic [2:0] JOB_A_Q  = 3'd7;

	localparam logic [1:0] PH_A = 2'd0;
	localparam logic [1:0] PH_B = 2'd1;
	localparam logic [1:0] PH_C = 2'd2;

	logic [3:0]                          st_q;
	logic [2:0]                          job_q;
	logic [1:0]                          ph_q;
	logic                                out_valid_q;

	logic signed [olp_pkg::CFG_W-1:0]    q_volt_q;
	logic signed [olp_pkg::CFG_W-1:0]    d_volt_q;
	logic [olp_pkg::CFG_W-1:0]           speed_q;
	logic [olp_pkg::CFG_W-1:0]           supply_q;
	logic [olp_pkg::CFG_W-1:0]           limit_q;
	logic [olp_pkg::ANG_W-1:0]           angle_q;

	logic [olp_pkg::CFG_W-1:0]           dt_q;
	logic signed [15:0]                  s_q;
	logic signed [15:0]                  c_q;
	logic signed [olp_pkg::MCAND_W-1:0]  u1_q;
	logic signed [olp_pkg::MCAND_W-1:0]  u3_q;
	logic signed [olp_pkg::V_W-1:0]      va_q;
	logic signed [olp_pkg::V_W-1:0]      vb_q;
	logic signed [olp_pkg::V_W-1:0]      vc_q;
	logic [olp_pkg::CNT_W-1:0]           ca_q;
	logic [olp_pkg::CNT_W-1:0]           cb_q;
	logic [olp_pkg::CNT_W-1:0]           cc_q;
	logic [olp_pkg::CNT_W-1:0]           out_a_q;
	logic [olp_pkg::CNT_W-1:0]           out_b_q;
	logic [olp_pkg::CNT_W-1:0]           out_c_q;
	logic [olp_pkg::ANG_W-1:0]           out_ang_q;

	logic                                mac_start;
	logic                                mac_clear;
	logic                                mac_signed;
	logic signed [olp_pkg::MCAND_W-1:0]  mac_mcand;
	logic [olp_pkg::MPLIER_W-1:0]        mac_mplier;
	logic                                mac_done;
	logic signed [olp_pkg::V_W-1:0]      mac_acc;

	logic                                cnt_start;
	logic                                cnt_done;
	logic [olp_pkg::CNT_W-1:0]           cnt_count;
	logic signed [olp_pkg::V_W-1:0]      cnt_v;

	logic signed [olp_pkg::MCAND_W-1:0]  k_const;
	logic signed [olp_pkg::MCAND_W-1:0]  s_ext;
	logic signed [olp_pkg::MCAND_W-1:0]  c_ext;
	logic signed [olp_pkg::MCAND_W-1:0]  s_half;
	logic signed [olp_pkg::MCAND_W-1:0]  c_half;

	logic tick_acc;
	logic out_free;

	assign tick_acc = tick.valid && tick.ready;
	assign out_free = !out_valid_q || pwm.ready;

	assign k_const = olp_pkg::MCAND_W'(olp_pkg::K_SQRT3_2);
	assign s_ext   = {{(olp_pkg::MCAND_W - 16){s_q[15]}}, s_q};
	assign c_ext   = {{(olp_pkg::MCAND_W - 16){c_q[15]}}, c_q};
	assign s_half  = {{(olp_pkg::MCAND_W - 30){s_q[15]}}, s_q, 14'b0};
	assign c_half  = {{(olp_pkg::MCAND_W - 30){c_q[15]}}, c_q, 14'b0};

	assign mac_start = (st_q == ST_ANG_GO) || (st_q == ST_MUL_GO);

	always_comb begin
		mac_clear  = 1'b1;
		mac_signed = 1'b1;
		mac_mcand  = '0;
		mac_mplier = '0;
		if (st_q == ST_ANG_GO) begin
			mac_signed = 1'b0;
			mac_mcand  = olp_pkg::MCAND_W'(speed_q);
			mac_mplier = dt_q;
		end else begin
			case (job_q)
				JOB_KS: begin
					mac_mcand  = k_const;
					mac_mplier = s_q;
				end
				JOB_KC: begin
					mac_mcand  = k_const;
					mac_mplier = c_q;
				end
				JOB_B_D: begin
					mac_mcand  = u1_q - c_half;
					mac_mplier = d_volt_q;
				end
				JOB_B_Q: begin
					mac_clear  = 1'b0;
					mac_mcand  = u3_q + s_half;
					mac_mplier = q_volt_q;
				end
				JOB_C_D: begin
					mac_mcand  = -u1_q - c_half;
					mac_mplier = d_volt_q;
				end
				JOB_C_Q: begin
					mac_clear  = 1'b0;
					mac_mcand  = s_half - u3_q;
					mac_mplier = q_volt_q;
				end
				JOB_A_D: begin
					mac_mcand  = c_ext;
					mac_mplier = d_volt_q;
				end
				JOB_A_Q: begin
					mac_clear  = 1'b0;
					mac_mcand  = -s_ext;
					mac_mplier = q_volt_q;
				end
				default: ;
			endcase
		end
	end

	olp_smac u_smac (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mac_start),
		.clear   (mac_clear),
		.msigned (mac_signed),
		.mcand   (mac_mcand),
		.mplier  (mac_mplier),
		.done    (mac_done),
		.acc     (mac_acc)
	);

	assign cnt_start = (st_q == ST_CNT_GO);

	always_comb begin
		case (ph_q)
			PH_A:    cnt_v = va_q;
			PH_B:    cnt_v = vb_q;
			default: cnt_v = vc_q;
		endcase
	end

	olp_cnt u_cnt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cnt_start),
		.v      (cnt_v),
		.supply (supply_q),
		.limit  (limit_q),
		.done   (cnt_done),
		.count  (cnt_count)
	);

	// control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			job_q       <= JOB_KS;
			ph_q        <= PH_A;
			out_valid_q <= 1'b0;
			q_volt_q    <= -16'sd256;
			d_volt_q    <= '0;
			speed_q     <= 16'd75;
			supply_q    <= 16'd3072;
			limit_q     <= 16'd3072;
			angle_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					olp_pkg::REG_Q_VOLT:  q_volt_q <= cfg_data;
					olp_pkg::REG_D_VOLT:  d_volt_q <= cfg_data;
					olp_pkg::REG_SPEED:   speed_q  <= cfg_data;
					olp_pkg::REG_SUPPLY:  supply_q <= cfg_data;
					olp_pkg::REG_V_LIMIT: limit_q  <= cfg_data;
					default: ;
				endcase
			end

			if (pwm.valid && pwm.ready)
				out_valid_q <= 1'b0;

			case (st_q)
				ST_IDLE: begin
					if (tick_acc)
						st_q <= ST_ANG_GO;
				end
				ST_ANG_GO: st_q <= ST_ANG_WAIT;
				ST_ANG_WAIT: begin
					if (mac_done) begin
						angle_q <= angle_q + mac_acc[25:10];
						st_q    <= ST_TRIG;
					end
				end
				ST_TRIG: begin
					job_q <= JOB_KS;
					st_q  <= ST_MUL_GO;
				end
				ST_MUL_GO: st_q <= ST_MUL_WAIT;
				ST_MUL_WAIT: begin
					if (mac_done) begin
						job_q <= job_q + 1'b1;
						if (job_q == JOB_A_Q) begin
							ph_q <= PH_A;
							st_q <= ST_CNT_GO;
						end else begin
							st_q <= ST_MUL_GO;
						end
					end
				end
				ST_CNT_GO: st_q <= ST_CNT_WAIT;
				ST_CNT_WAIT: begin
					if (cnt_done) begin
						ph_q <= ph_q + 1'b1;
						st_q <= (ph_q == PH_C) ? ST_DONE : ST_CNT_GO;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (tick_acc)
			dt_q <= tick.elapsed_us;
		if (st_q == ST_TRIG) begin
			s_q <= olp_pkg::sin_q15(angle_q);
			c_q <= olp_pkg::sin_q15(angle_q + 16'h4000);
		end
		if (st_q == ST_MUL_WAIT && mac_done) begin
			case (job_q)
				JOB_KS:  u1_q <= mac_acc[olp_pkg::MCAND_W-1:0];
				JOB_KC:  u3_q <= mac_acc[olp_pkg::MCAND_W-1:0];
				JOB_B_Q: vb_q <= mac_acc;
				JOB_C_Q: vc_q <= mac_acc;
				JOB_A_Q: va_q <= mac_acc <<< 15;
				default: ;
			endcase
		end
		if (st_q == ST_CNT_WAIT && cnt_done) begin
			case (ph_q)
				PH_A:    ca_q <= cnt_count;
				PH_B:    cb_q <= cnt_count;
				default: cc_q <= cnt_count;
			endcase
		end
		if (st_q == ST_DONE && out_free) begin
			out_a_q   <= ca_q;
			out_b_q   <= cb_q;
			out_c_q   <= cc_q;
			out_ang_q <= angle_q;
		end
	end

	assign tick.ready    = (st_q == ST_IDLE);
	assign pwm.valid     = out_valid_q;
	assign pwm.compare_a = out_a_q;
	assign pwm.compare_b = out_b_q;
	assign pwm.compare_c = out_c_q;
	assign pwm.angle_now = out_ang_q;

endmodule

/* sv/olp_chk.sv */
`timescale 1ns / 1ps
// Port-level checks for the open-loop PWM block, bound to the top level.
// Depends on olp_pkg and open_loop_three_phase_pwm.
module olp_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          tick_valid,
	input logic                          tick_ready,
	input logic                          pwm_valid,
	input logic                          pwm_ready,
	input logic [olp_pkg::CNT_W-1:0]     compare_a,
	input logic [olp_pkg::CNT_W-1:0]     compare_b,
	input logic [olp_pkg::CNT_W-1:0]     compare_c
);

	// a waiting result holds its counts
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pwm_valid && !pwm_ready |=> pwm_valid && $stable(compare_a)
			&& $stable(compare_b) && $stable(compare_c))
		else $error("pwm item changed while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		pwm_valid |-> compare_a <= olp_pkg::CNT_W'(olp_pkg::PWM_PERIOD)
			&& compare_b <= olp_pkg::CNT_W'(olp_pkg::PWM_PERIOD)
			&& compare_c <= olp_pkg::CNT_W'(olp_pkg::PWM_PERIOD))
		else $error("compare count above period");

	// a taken tick keeps the input closed for the work that follows
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && tick_ready |=> !tick_ready ##1 !tick_ready)
		else $error("tick accepted while busy");

	// no result can appear right after a tick is taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && tick_ready && !pwm_valid |=> !pwm_valid)
		else $error("result appeared too early");

endmodule

bind open_loop_three_phase_pwm olp_chk u_olp_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.tick_valid (tick.valid),
	.tick_ready (tick.ready),
	.pwm_valid  (pwm.valid),
	.pwm_ready  (pwm.ready),
	.compare_a  (pwm.compare_a),
	.compare_b  (pwm.compare_b),
	.compare_c  (pwm.compare_c)
);

/* tb/open_loop_three_phase_pwm_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the open-loop three-phase PWM block: tick items in, compare items
// out, checked against an in-bench angle/Park/Clarke predictor. Depends on olp_pkg, olp_if.
module open_loop_three_phase_pwm_tb;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam int LONG_HOLD      = 800;

	typedef struct {
		logic [olp_pkg::CNT_W-1:0] ca;
		logic [olp_pkg::CNT_W-1:0] cb;
		logic [olp_pkg::CNT_W-1:0] cc;
		logic [olp_pkg::ANG_W-1:0] ang;
	} duty_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [olp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [olp_pkg::CFG_W-1:0] cfg_data = '0;

	olp_tick_if tick_ch();
	olp_pwm_if  pwm_ch();

	open_loop_three_phase_pwm u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch.sink),
		.pwm       (pwm_ch.source),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state
	int  unsigned  sine_q15_tab [olp_pkg::TBL_N];
	logic signed [15:0] m_vq = -16'sd256;
	logic signed [15:0] m_vd = 16'sd0;
	logic [15:0] m_speed = 16'd75;
	logic [15:0] m_supply = 16'd3072;
	logic [15:0] m_limit = 16'd3072;
	logic [15:0] m_angle = 16'd0;

	duty_t duty_q[$];
	int errors = 0;
	int ticks_sent = 0;
	int duties_seen = 0;
	int cfg_writes = 0;
	bit quiet = 1'b0;
	bit hold_request = 1'b0;
	int idle_cycles = 0;

	function automatic longint sine_of(logic [15:0] ang);
		logic [1:0] quad;
		int unsigned idx, pos;
		longint v;
		quad = ang[15:14];
		idx  = 32'(ang[13:6]);
		pos  = quad[0] ? olp_pkg::TBL_N - idx : idx;
		v    = (pos >= olp_pkg::TBL_N) ? 64'sd32767 : longint'(sine_q15_tab[pos]);
		return quad[1] ? -v : v;
	endfunction

	function automatic logic [olp_pkg::CNT_W-1:0] phase_count(longint v);
		longint lim, den, n;
		if (m_supply == 0)
			return '0;
		lim = longint'(m_limit) * 64'sd1073741824;
		v = v + longint'(m_supply) * 64'sd536870912;
		if (v < 0)
			v = 0;
		if (v > lim)
			v = lim;
		den = longint'(m_supply) << 30;
		n = (v * olp_pkg::PWM_PERIOD) / den;
		if (n > olp_pkg::PWM_PERIOD)
			n = olp_pkg::PWM_PERIOD;
		return n[olp_pkg::CNT_W-1:0];
	endfunction

	function automatic duty_t predict_duty(logic [15:0] dt);
		longint s, c, d, q, va, vb, vc, k, h;
		duty_t r;
		m_angle = m_angle + 16'((longint'(m_speed) * longint'(dt)) >> 10);
		s = sine_of(m_angle);
		c = sine_of(m_angle + 16'h4000);
		d = longint'(m_vd);
		q = longint'(m_vq);
		k = 28378;
		h = 16384;
		va = (c * d - s * q) * 32768;
		vb = (k * s - h * c) * d - (-k * c - h * s) * q;
		vc = (-k * s - h * c) * d - (k * c - h * s) * q;
		r.ca = phase_count(va);
		r.cb = phase_count(vb);
		r.cc = phase_count(vc);
		r.ang = m_angle;
		return r;
	endfunction

	task automatic build_table();
		longint unsigned x, x2, t, p;
		for (int i = 0; i < olp_pkg::TBL_N; i++) begin
			x  = longint'(i) << (16 - olp_pkg::SINE_TABLE_BITS);
			x2 = (x * x) >> 16;
			t  = 42334 - ((x2 * 5223) >> 16);
			t  = 102944 - ((x2 * t) >> 16);
			p  = ((x * t) >> 16) >> 1;
			if (p > 32767)
				p = 32767;
			sine_q15_tab[i] = 32'(p);
		end
	endtask

	// called at a rising edge; leaves valid high after the item is taken
	task automatic send_tick(logic [15:0] dt);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			tick_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.elapsed_us <= dt;
		do @(posedge clk); while (!tick_ch.ready);
		duty_q.push_back(predict_duty(dt));
		ticks_sent++;
	endtask

	task automatic drain();
		tick_ch.valid <= 1'b0;
		while (duty_q.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_cfg(logic [olp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			olp_pkg::REG_Q_VOLT:  m_vq = val;
			olp_pkg::REG_D_VOLT:  m_vd = val;
			olp_pkg::REG_SPEED:   m_speed = val;
			olp_pkg::REG_SUPPLY:  m_supply = val;
			olp_pkg::REG_V_LIMIT: m_limit = val;
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic set_all(logic [15:0] q, logic [15:0] d, logic [15:0] spd,
			logic [15:0] sup, logic [15:0] lim);
		drain();
		write_cfg(olp_pkg::REG_Q_VOLT, q);
		write_cfg(olp_pkg::REG_D_VOLT, d);
		write_cfg(olp_pkg::REG_SPEED, spd);
		write_cfg(olp_pkg::REG_SUPPLY, sup);
		write_cfg(olp_pkg::REG_V_LIMIT, lim);
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h7FFF;
			3: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_defaults();
		send_tick(16'd0);
		send_tick(16'hFFFF);
		send_tick(16'd1);
		send_tick(16'd1024);
		send_tick(16'h5555);
		send_tick(16'hAAAA);
	endtask

	task automatic test_extremes();
		// full-scale commands, fast spin, limit far above supply so duty saturates
		set_all(16'h7FFF, 16'h8000, 16'hFFFF, 16'd1, 16'hFFFF);
		repeat (4) send_tick(16'($urandom));
		// zero limit: every phase clamps to zero
		set_all(16'h8000, 16'h7FFF, 16'd4096, 16'hFFFF, 16'd0);
		repeat (3) send_tick(16'($urandom));
		// zero supply
		set_all(16'h0100, 16'h0000, 16'd300, 16'd0, 16'd3072);
		repeat (3) send_tick(16'($urandom));
		// quadrant boundaries: a zero step, then steps of exactly a quarter turn
		set_all(16'hFE00, 16'h0080, 16'd1024, 16'd3072, 16'd2048);
		send_tick(16'd0);
		repeat (5) send_tick(16'h4000);
		send_tick(16'h0040);
	endtask

	task automatic test_random_phases(int phases, int per_phase);
		for (int p = 0; p < phases; p++) begin
			set_all(pick_word(), pick_word(), pick_word(), pick_word(), pick_word());
			repeat (per_phase) send_tick(pick_word());
		end
	endtask

	task automatic test_backpressure();
		hold_request = 1'b1;
		repeat (6) send_tick(16'($urandom));
	endtask

	task automatic test_pause();
		repeat (5) send_tick(16'($urandom));
		drain();
		repeat (5) send_tick(16'($urandom));
	endtask

	// result side: random ready bursts (steady ready when quiet), long hold on request, checks every item
	int burst_left = 0;
	bit burst_ready = 1'b1;
	int hold_left = 0;
	always @(posedge clk) begin
		duty_t e;
		if (pwm_ch.valid && pwm_ch.ready) begin
			duties_seen++;
			if (duty_q.size() == 0) begin
				$display("%0t: unexpected duty item a=%0d b=%0d c=%0d ang=%0d", $time,
					pwm_ch.compare_a, pwm_ch.compare_b, pwm_ch.compare_c, pwm_ch.angle_now);
				errors++;
			end else begin
				e = duty_q.pop_front();
				if (pwm_ch.compare_a !== e.ca || pwm_ch.compare_b !== e.cb ||
						pwm_ch.compare_c !== e.cc || pwm_ch.angle_now !== e.ang) begin
					$display("%0t: duty mismatch exp a=%0d b=%0d c=%0d ang=%0d", $time,
						e.ca, e.cb, e.cc, e.ang);
					$display("%0t:               got a=%0d b=%0d c=%0d ang=%0d", $time,
						pwm_ch.compare_a, pwm_ch.compare_b, pwm_ch.compare_c,
						pwm_ch.angle_now);
					errors++;
				end
			end
		end
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			pwm_ch.ready <= 1'b0;
		end else if (quiet) begin
			pwm_ch.ready <= 1'b1;
		end else begin
			if (burst_left == 0) begin
				burst_ready = ($urandom_range(0, 1) != 0);
				burst_left = burst_ready ? int'($urandom_range(1, 60))
				                         : int'($urandom_range(1, 19));
			end
			burst_left--;
			pwm_ch.ready <= burst_ready;
		end
	end

	// watchdog on cycles where neither channel moves an item
	always @(posedge clk) begin
		if ((tick_ch.valid && tick_ch.ready) || (pwm_ch.valid && pwm_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d items outstanding", $time, duty_q.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		tick_ch.valid = 1'b0;
		tick_ch.elapsed_us = '0;
		pwm_ch.ready = 1'b0;
		build_table();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_extremes();
		test_random_phases(8, 180);
		test_backpressure();
		test_pause();
		test_random_phases(4, 60);
		drain();
		quiet = 1'b1;
		test_random_phases(2, 30);

		drain();
		repeat (300) @(posedge clk);
		if (duty_q.size() != 0) begin
			$display("%0t: %0d duty items never arrived", $time, duty_q.size());
			errors++;
		end
		$display("covered %0d ticks, %0d duty items, %0d register writes, %0d errors",
			ticks_sent, duties_seen, cfg_writes, errors);
		$display("including saturation, zero supply, zero limit and long output stalls");
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* filelist.f */
sv/olp_pkg.sv
sv/olp_if.sv
sv/olp_smac.sv
sv/olp_cnt.sv
sv/open_loop_three_phase_pwm.sv
sv/olp_chk.sv
tb/open_loop_three_phase_pwm_tb.sv
